/* rtl/pdf_pkg.sv */
`default_nettype none

package pdf_pkg;

    localparam int ENTRIES = 64;
    localparam int PTR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HASH_W  = 32;
    localparam int BYTE_W  = 8;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    // query traveling down the compare chain
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [HASH_W-1:0] q;
    } t_link;

endpackage

`default_nettype wire

/* rtl/pdf_fold.sv */
`default_nettype none

module pdf_fold (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [pdf_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                       i_last_byte,
    output pdf_pkg::t_link                  o_launch
);

    logic [pdf_pkg::HASH_W-1:0] r_hash;
    logic                       r_launch_vld;
    logic [pdf_pkg::HASH_W-1:0] r_launch_q;
    logic [pdf_pkg::HASH_W-1:0] w_fold;

    assign w_fold = (r_hash ^ {{(pdf_pkg::HASH_W-pdf_pkg::BYTE_W){1'b0}}, i_data_byte})
                    * pdf_pkg::FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash       <= pdf_pkg::FNV_BASIS;
            r_launch_vld <= 1'b0;
        end else begin
            r_launch_vld <= 1'b0;
            if (i_accept) begin
                if (i_last_byte) begin
                    r_hash       <= pdf_pkg::FNV_BASIS;
                    r_launch_vld <= 1'b1;
                end else begin
                    r_hash <= w_fold;
                end
            end
        end
    end

    // payload of the launch word, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_accept && i_last_byte) begin
            r_launch_q <= w_fold;
        end
    end

    assign o_launch = '{vld: r_launch_vld, hit: 1'b0, q: r_launch_q};

endmodule

`default_nettype wire

/* rtl/pdf_cell.sv */
`default_nettype none

module pdf_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [pdf_pkg::HASH_W-1:0] i_wr_data,
    input  wire pdf_pkg::t_link             i_link,
    output pdf_pkg::t_link                  o_link
);

    logic [pdf_pkg::HASH_W-1:0] r_entry;
    logic                       r_vld;
    logic                       r_hit;
    logic [pdf_pkg::HASH_W-1:0] r_q;

    // store starts all zero, so a zero hash counts as seen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_entry <= i_wr_data;
            end
            r_vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= i_link.q;
        r_hit <= i_link.hit | (i_link.q == r_entry);
    end

    assign o_link = '{vld: r_vld, hit: r_hit, q: r_q};

endmodule

`default_nettype wire

/* rtl/packet_dedup_fnv1a_unit.sv */
`default_nettype none
// Channel   Ports                                   Handshake
// input     i_data_byte, i_last_byte                start && !busy
// result    o_packet_hash, o_already_seen           o_valid, one cycle, no stall
//
// A byte not marked last is folded into r_hash; start may stay high every cycle.
// A last byte sends its hash down a chain of ENTRIES compare cells, one cell per
// cycle, after the launch register: the result shows at the chain's end and busy
// drops after it, and no new byte is taken until then. A new hash is written in
// the cycle the result shows. Reset clears the hash to the offset basis, the store
// to zero and the ring pointer. Results cannot be stalled.

module packet_dedup_fnv1a_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic [pdf_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                       i_last_byte,
    output logic                            busy,
    output logic                            o_valid,
    output logic [pdf_pkg::HASH_W-1:0]      o_packet_hash,
    output logic                            o_already_seen
);

    logic                          w_accept;
    pdf_pkg::t_link                w_link [0:pdf_pkg::ENTRIES];
    logic [pdf_pkg::ENTRIES:0]     w_vld_vec;
    logic [pdf_pkg::ENTRIES-1:0]   w_wr_en;
    logic                          w_record;
    logic                          r_busy;
    logic [pdf_pkg::PTR_W-1:0]     r_wp;
    logic [pdf_pkg::PTR_W-1:0]     n_wp;
    pdf_pkg::t_link                w_tail;

    assign w_accept = start && !r_busy;
    assign w_tail   = w_link[pdf_pkg::ENTRIES];
    assign w_record = w_tail.vld && !w_tail.hit;

    pdf_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_launch    (w_link[0])
    );

    for (genvar gi = 0; gi < pdf_pkg::ENTRIES; gi++) begin : g_cell
        assign w_wr_en[gi] = w_record && (r_wp == pdf_pkg::PTR_W'(gi));

        pdf_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wr_en[gi]),
            .i_wr_data (w_tail.q),
            .i_link    (w_link[gi]),
            .o_link    (w_link[gi+1])
        );
    end

    for (genvar gv = 0; gv <= pdf_pkg::ENTRIES; gv++) begin : g_vld
        assign w_vld_vec[gv] = w_link[gv].vld;
    end

    always_comb begin
        if (r_wp == pdf_pkg::PTR_W'(pdf_pkg::ENTRIES - 1)) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_wp   <= '0;
        end else begin
            if (w_accept && i_last_byte) begin
                r_busy <= 1'b1;
            end else if (w_tail.vld) begin
                r_busy <= 1'b0;
            end
            if (w_record) begin
                r_wp <= n_wp;
            end
        end
    end

    assign busy           = r_busy;
    assign o_valid        = w_tail.vld;
    assign o_packet_hash  = w_tail.q;
    assign o_already_seen = w_tail.hit;

    // only one packet in the chain at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld_vec))
        else $error("more than one query in compare chain");

    a_busy_covers_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_vld_vec) |-> r_busy)
        else $error("query in chain while not busy");

    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_byte) |=> r_busy)
        else $error("busy not raised after last word");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !r_busy)
        else $error("busy held after result");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wr_en))
        else $error("more than one store entry written");

endmodule

`default_nettype wire

/* tb/tb_packet_dedup_fnv1a_unit.sv */
`timescale 1ns / 1ps

module tb_packet_dedup_fnv1a_unit;

    localparam logic [31:0] HASH_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] HASH_PRIME = 32'h0100_0193;
    localparam int          DEPTH      = pdf_pkg::ENTRIES;
    localparam int          N_ITEMS    = 450;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_word;

    typedef struct packed {
        logic [31:0] hash;
        logic        seen;
    } t_verdict;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic [pdf_pkg::BYTE_W-1:0]    i_data_byte = '0;
    logic                          i_last_byte = 1'b0;
    logic                          busy;
    logic                          o_valid;
    logic [pdf_pkg::HASH_W-1:0]    o_packet_hash;
    logic                          o_already_seen;

    packet_dedup_fnv1a_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_packet_hash  (o_packet_hash),
        .o_already_seen (o_already_seen)
    );

    always #5 i_clk = ~i_clk;

    // pending words for the driver, and verdicts still owed by the block
    t_word       word_q[$];
    t_verdict    verdict_q[$];
    int          errors = 0;
    logic        took   = 1'b0;

    // predictor state
    logic [31:0] run_hash;
    logic [31:0] seen_tbl[DEPTH];
    int          ring_ptr;

    // packet history, flattened, for replays
    logic [7:0]  hist_bytes[$];
    int          hist_start[$];
    int          hist_len[$];
    logic [7:0]  scratch[32];
    int          scratch_len;
    int          n_items = 0;

    function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'h0, b}) * HASH_PRIME;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t ns: %s: expected %08h got %08h", $time, what, want, got);
        errors++;
    endtask

    task automatic send_scratch();
        hist_start.push_back(hist_bytes.size());
        hist_len.push_back(scratch_len);
        for (int j = 0; j < scratch_len; j++) begin
            hist_bytes.push_back(scratch[j]);
            word_q.push_back('{data: scratch[j], last: (j == scratch_len - 1)});
        end
        n_items += scratch_len;
    endtask

    // result check, then prediction for the word taken at this edge
    always @(posedge i_clk) begin : monitor
        t_verdict    want;
        logic [31:0] h;
        logic        hit;
        if (!i_rst_n) begin
            took <= 1'b0;
            run_hash = HASH_BASIS;
            for (int k = 0; k < DEPTH; k++) seen_tbl[k] = '0;
            ring_ptr = 0;
        end else begin
            if (o_valid) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, o_packet_hash);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_packet_hash !== want.hash)
                        report_mismatch("packet_hash", want.hash, o_packet_hash);
                    if (o_already_seen !== want.seen)
                        report_mismatch("already_seen", {31'h0, want.seen},
                                        {31'h0, o_already_seen});
                end
            end
            took <= start && (busy == 1'b0);
            if (start && (busy == 1'b0)) begin
                h = fnv_fold(run_hash, i_data_byte);
                if (!i_last_byte) begin
                    run_hash = h;
                end else begin
                    hit = 1'b0;
                    for (int k = 0; k < DEPTH; k++)
                        if (seen_tbl[k] == h) hit = 1'b1;
                    if (!hit) begin
                        seen_tbl[ring_ptr] = h;
                        ring_ptr = (ring_ptr + 1) % DEPTH;
                    end
                    verdict_q.push_back('{hash: h, seen: hit});
                    run_hash = HASH_BASIS;
                end
            end
        end
    end

    // bursts of words with random gaps; a word stays up until taken
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : driver
        t_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !took)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                start       <= 1'b1;
                i_data_byte <= w.data;
                i_last_byte <= w.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] pinv;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [31:0] h4;
        bit   [15:0] fwd[bit [31:0]];
        bit   [15:0] pair;
        logic [7:0]  zero_pkt[5];
        logic        found;
        int          r;
        int          pick;
        int          base;

        // Find a 5-byte packet whose hash is zero: two bytes forward from the
        // basis meet three bytes unwound back from a zero result.
        pinv = HASH_PRIME;
        repeat (5) pinv = pinv * (32'd2 - HASH_PRIME * pinv);
        for (int c0 = 0; c0 < 256; c0++)
            for (int c1 = 0; c1 < 256; c1++)
                fwd[fnv_fold(fnv_fold(HASH_BASIS, c0[7:0]), c1[7:0])] = {c0[7:0], c1[7:0]};
        found = 1'b0;
        for (int x = 0; x < 256 && !found; x++) begin
            h4 = x;
            for (int c3 = 0; c3 < 256 && !found; c3++) begin
                h3 = (h4 * pinv) ^ c3;
                for (int c2 = 0; c2 < 256 && !found; c2++) begin
                    h2 = (h3 * pinv) ^ c2;
                    if (fwd.exists(h2)) begin
                        found = 1'b1;
                        pair  = fwd[h2];
                        zero_pkt[0] = pair[15:8];
                        zero_pkt[1] = pair[7:0];
                        zero_pkt[2] = c2[7:0];
                        zero_pkt[3] = c3[7:0];
                        zero_pkt[4] = x[7:0];
                    end
                end
            end
        end

        // directed: zero hash while the store is clear, byte extremes, repeats
        if (found) begin
            repeat (2) begin
                for (int j = 0; j < 5; j++) scratch[j] = zero_pkt[j];
                scratch_len = 5;
                send_scratch();
            end
        end
        scratch_len = 1;
        scratch[0] = 8'h00; send_scratch();
        scratch[0] = 8'hff; send_scratch();
        scratch[0] = 8'h00; send_scratch();
        repeat (2) begin
            scratch[0] = 8'ha5; scratch[1] = 8'h5a; scratch[2] = 8'h00; scratch[3] = 8'hff;
            scratch_len = 4;
            send_scratch();
        end

        // random: fresh packets, replays (recent and old), the zero-hash packet
        while (n_items < N_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                if ($urandom_range(0, 1) == 0 && hist_start.size() > 64)
                    pick = $urandom_range(hist_start.size() - 64, hist_start.size() - 1);
                else
                    pick = $urandom_range(0, hist_start.size() - 1);
                base        = hist_start[pick];
                scratch_len = hist_len[pick];
                for (int j = 0; j < scratch_len; j++) scratch[j] = hist_bytes[base + j];
            end else if (r < 34 && found) begin
                for (int j = 0; j < 5; j++) scratch[j] = zero_pkt[j];
                scratch_len = 5;
            end else begin
                scratch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                          : $urandom_range(1, 8);
                for (int j = 0; j < scratch_len; j++) scratch[j] = $urandom_range(0, 255);
            end
            send_scratch();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(word_q.size() == 0 && !start && verdict_q.size() == 0))
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        if (verdict_q.size() > 0)
            report_mismatch("results never delivered", verdict_q.size(), '0);
        if (errors == 0) begin
            $display("packet_dedup_fnv1a_unit: match");
        end else begin
            $display("packet_dedup_fnv1a_unit: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("packet_dedup_fnv1a_unit: mismatch");
        $finish;
    end

endmodule
